// ----- rtl/mtep_pkg.sv -----
package mtep_pkg;

	localparam logic [7:0] STATUS_BIT  = 8'h80;
	localparam logic [7:0] DATA_MASK   = 8'h7f;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [7:0] SYS_BASE    = 8'hf0;
	localparam logic [7:0] META_STATUS = 8'hff;
	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_NOTE_ON  = 4'h9;
	localparam logic [3:0] HI_PROGRAM  = 4'hc;
	localparam logic [3:0] HI_PRESSURE = 4'hd;
	localparam logic [1:0] VARLEN_LAST = 2'd3;
	localparam int         FIFO_DEPTH  = 4;

	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_DATA1     = 4'd2,
		PH_DATA2     = 4'd3,
		PH_META_TYPE = 4'd4,
		PH_META_LEN  = 4'd5,
		PH_META_BODY = 4'd6,
		PH_SYSEX_LEN = 4'd7,
		PH_SKIP      = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		K_OFF   = 3'd0,
		K_ON    = 3'd1,
		K_TEMPO = 3'd2,
		K_DONE  = 3'd3,
		K_ERR   = 3'd4
	} kind_t;

	typedef struct packed {
		logic        has_ev;
		kind_t       kind;
		logic [4:0]  track;
		logic [31:0] time_ev;
		logic [3:0]  channel;
		logic [7:0]  note;
		logic [7:0]  velocity;
		logic [7:0]  instrument;
		logic [23:0] tempo;
		logic        has_done;
		logic [31:0] time_done;
	} cmd_t;

endpackage

// ----- rtl/mtep_fifo.sv -----
module mtep_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mtep_pkg::cmd_t  wr_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output mtep_pkg::cmd_t  rd_cmd
);

	localparam int AW = $clog2(mtep_pkg::FIFO_DEPTH);

	mtep_pkg::cmd_t mem_q [mtep_pkg::FIFO_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign full   = (count_q == (AW+1)'(mtep_pkg::FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/mtep_front.sv -----
module mtep_front #(
	parameter int TRACKS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_accept,
	input  logic [4:0]      track_id,
	input  logic [7:0]      data_byte,
	input  logic            track_end,
	output logic            push,
	output mtep_pkg::cmd_t  cmd
);

	localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	mtep_pkg::phase_t phase_q [TRACKS];
	logic [1:0]       vcnt_q  [TRACKS];
	logic [27:0]      vacc_q  [TRACKS];
	logic [31:0]      abs_q   [TRACKS];
	logic [7:0]       rs_q    [TRACKS];
	logic [7:0]       cs_q    [TRACKS];
	logic [7:0]       fd_q    [TRACKS];
	logic [7:0]       mt_q    [TRACKS];
	logic [27:0]      skip_q  [TRACKS];
	logic [23:0]      tacc_q  [TRACKS];
	logic             err_q   [TRACKS];
	logic [7:0]       prog_q  [16];

	logic [8:0]       tid_ext;
	logic [IW-1:0]    idx;
	logic             in_range;
	logic             wr_en;

	mtep_pkg::phase_t ph_n;
	logic [1:0]       vcnt_n;
	logic [27:0]      vacc_n;
	logic [31:0]      abs_n;
	logic [7:0]       rs_n, cs_n, fd_n, mt_n;
	logic [27:0]      skip_n;
	logic [23:0]      tacc_n;
	logic             err_n;
	logic             prog_we;
	logic [3:0]       prog_ch;
	logic [27:0]      nacc;
	logic             vdone;
	logic [7:0]       ev;
	logic [7:0]       st;
	logic [27:0]      skip_dec;
	logic             data_in;

	assign tid_ext  = {4'b0, track_id};
	assign idx      = tid_ext[IW-1:0];
	assign in_range = (tid_ext < 9'(TRACKS));
	assign wr_en    = in_accept && in_range;
	assign push     = wr_en && (cmd.has_ev || cmd.has_done);

	always_comb begin
		ph_n     = phase_q[idx];
		vcnt_n   = vcnt_q[idx];
		vacc_n   = vacc_q[idx];
		abs_n    = abs_q[idx];
		rs_n     = rs_q[idx];
		cs_n     = cs_q[idx];
		fd_n     = fd_q[idx];
		mt_n     = mt_q[idx];
		skip_n   = skip_q[idx];
		tacc_n   = tacc_q[idx];
		err_n    = err_q[idx];
		prog_we  = 1'b0;
		prog_ch  = cs_q[idx][3:0];
		nacc     = {vacc_q[idx][20:0], data_byte[6:0]};
		vdone    = !(data_byte[7] && (vcnt_q[idx] < mtep_pkg::VARLEN_LAST));
		ev       = (data_byte < mtep_pkg::STATUS_BIT) ? rs_q[idx] : data_byte;
		st       = cs_q[idx];
		skip_dec = skip_q[idx] - 28'd1;
		data_in  = 1'b0;
		cmd      = '0;
		cmd.track = track_id;

		if (!err_q[idx]) begin
			case (phase_q[idx])
				mtep_pkg::PH_DELTA: begin
					if (vdone) begin
						abs_n  = abs_q[idx] + {4'b0, nacc};
						vacc_n = '0;
						vcnt_n = '0;
						ph_n   = mtep_pkg::PH_STATUS;
					end else begin
						vacc_n = nacc;
						vcnt_n = vcnt_q[idx] + 2'd1;
					end
				end
				mtep_pkg::PH_STATUS: begin
					if (ev < mtep_pkg::STATUS_BIT) begin
						err_n       = 1'b1;
						cmd.has_ev  = 1'b1;
						cmd.kind    = mtep_pkg::K_ERR;
						cmd.time_ev = abs_q[idx];
					end else if (ev == mtep_pkg::META_STATUS) begin
						ph_n = mtep_pkg::PH_META_TYPE;
					end else begin
						if (ev < mtep_pkg::SYS_BASE)
							rs_n = ev;
						cs_n = ev;
						st   = ev;
						if (ev >= mtep_pkg::SYS_BASE) begin
							vcnt_n = '0;
							vacc_n = '0;
							ph_n   = mtep_pkg::PH_SYSEX_LEN;
						end else begin
							ph_n    = mtep_pkg::PH_DATA1;
							data_in = (data_byte < mtep_pkg::STATUS_BIT);
						end
					end
				end
				mtep_pkg::PH_DATA1: begin
					data_in = 1'b1;
				end
				mtep_pkg::PH_DATA2: begin
					ph_n = mtep_pkg::PH_DELTA;
					if (st[7:4] == mtep_pkg::HI_NOTE_OFF
							|| (st[7:4] == mtep_pkg::HI_NOTE_ON && data_byte == 8'd0)) begin
						cmd.has_ev  = 1'b1;
						cmd.kind    = mtep_pkg::K_OFF;
						cmd.time_ev = abs_q[idx];
						cmd.channel = st[3:0];
						cmd.note    = fd_q[idx];
					end else if (st[7:4] == mtep_pkg::HI_NOTE_ON) begin
						cmd.has_ev     = 1'b1;
						cmd.kind       = mtep_pkg::K_ON;
						cmd.time_ev    = abs_q[idx];
						cmd.channel    = st[3:0];
						cmd.note       = fd_q[idx];
						cmd.velocity   = data_byte;
						cmd.instrument = prog_q[st[3:0]];
					end
				end
				mtep_pkg::PH_META_TYPE: begin
					mt_n   = data_byte;
					vcnt_n = '0;
					vacc_n = '0;
					ph_n   = mtep_pkg::PH_META_LEN;
				end
				mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
					if (vdone) begin
						skip_n = nacc;
						vacc_n = '0;
						vcnt_n = '0;
						if (phase_q[idx] == mtep_pkg::PH_META_LEN
								&& mt_q[idx] == mtep_pkg::META_TEMPO) begin
							tacc_n = '0;
							if (nacc == '0) begin
								ph_n        = mtep_pkg::PH_DELTA;
								cmd.has_ev  = 1'b1;
								cmd.kind    = mtep_pkg::K_TEMPO;
								cmd.time_ev = abs_q[idx];
							end else begin
								ph_n = mtep_pkg::PH_META_BODY;
							end
						end else begin
							ph_n = (nacc == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
						end
					end else begin
						vacc_n = nacc;
						vcnt_n = vcnt_q[idx] + 2'd1;
					end
				end
				mtep_pkg::PH_META_BODY: begin
					case (vcnt_q[idx])
						2'd0:    tacc_n = tacc_q[idx] | {data_byte, 16'b0};
						2'd1:    tacc_n = tacc_q[idx] | {8'b0, data_byte, 8'b0};
						2'd2:    tacc_n = tacc_q[idx] | {16'b0, data_byte};
						default: tacc_n = tacc_q[idx];
					endcase
					if (vcnt_q[idx] < 2'd3)
						vcnt_n = vcnt_q[idx] + 2'd1;
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						vcnt_n      = '0;
						ph_n        = mtep_pkg::PH_DELTA;
						cmd.has_ev  = 1'b1;
						cmd.kind    = mtep_pkg::K_TEMPO;
						cmd.time_ev = abs_q[idx];
						cmd.tempo   = tacc_n;
					end
				end
				default: begin
					skip_n = skip_dec;
					if (skip_dec == '0)
						ph_n = mtep_pkg::PH_DELTA;
				end
			endcase

			if (data_in) begin
				fd_n    = data_byte;
				prog_ch = st[3:0];
				if (st[7:4] == mtep_pkg::HI_PROGRAM) begin
					prog_we = 1'b1;
					ph_n    = mtep_pkg::PH_DELTA;
				end else if (st[7:4] == mtep_pkg::HI_PRESSURE) begin
					ph_n = mtep_pkg::PH_DELTA;
				end else begin
					ph_n = mtep_pkg::PH_DATA2;
				end
			end
		end

		cmd.has_done  = track_end;
		cmd.time_done = abs_n;

		if (track_end) begin
			ph_n   = mtep_pkg::PH_DELTA;
			vcnt_n = '0;
			vacc_n = '0;
			abs_n  = '0;
			rs_n   = '0;
			cs_n   = '0;
			fd_n   = '0;
			mt_n   = '0;
			skip_n = '0;
			tacc_n = '0;
			err_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKS; i++) begin
				phase_q[i] <= mtep_pkg::PH_DELTA;
				vcnt_q[i]  <= '0;
				vacc_q[i]  <= '0;
				abs_q[i]   <= '0;
				rs_q[i]    <= '0;
				cs_q[i]    <= '0;
				fd_q[i]    <= '0;
				mt_q[i]    <= '0;
				skip_q[i]  <= '0;
				tacc_q[i]  <= '0;
				err_q[i]   <= 1'b0;
			end
			for (int c = 0; c < 16; c++)
				prog_q[c] <= '0;
		end else if (wr_en) begin
			phase_q[idx] <= ph_n;
			vcnt_q[idx]  <= vcnt_n;
			vacc_q[idx]  <= vacc_n;
			abs_q[idx]   <= abs_n;
			rs_q[idx]    <= rs_n;
			cs_q[idx]    <= cs_n;
			fd_q[idx]    <= fd_n;
			mt_q[idx]    <= mt_n;
			skip_q[idx]  <= skip_n;
			tacc_q[idx]  <= tacc_n;
			err_q[idx]   <= err_n;
			if (prog_we)
				prog_q[prog_ch] <= data_byte;
		end
	end

endmodule

// ----- rtl/mtep_back.sv -----
module mtep_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  mtep_pkg::cmd_t  rd_cmd,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [95:0]     m_tdata,
	output logic [2:0]      m_tuser,
	output logic            m_tlast
);

	logic        sent_q;
	logic        valid_q;
	logic [95:0] data_q;
	logic [2:0]  kind_q;
	logic        last_q;
	logic        load;
	logic        send_ev;

	assign load    = (!valid_q || m_tready) && !empty;
	assign send_ev = rd_cmd.has_ev && !sent_q;
	assign pop     = load && !(send_ev && rd_cmd.has_done);

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_ev) begin
				data_q <= {7'b0, rd_cmd.tempo, rd_cmd.instrument, rd_cmd.velocity,
					rd_cmd.note, rd_cmd.channel, rd_cmd.time_ev, rd_cmd.track};
				kind_q <= rd_cmd.kind;
				last_q <= !rd_cmd.has_done;
			end else begin
				data_q <= {7'b0, 24'b0, 8'b0, 8'b0, 8'b0, 4'b0, rd_cmd.time_done,
					rd_cmd.track};
				kind_q <= mtep_pkg::K_DONE;
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q  <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
			if (load)
				sent_q <= send_ev && rd_cmd.has_done;
		end
	end

endmodule

// ----- rtl/midi_track_event_parser.sv -----
// MIDI track event parser.
// Input stream: one track chunk byte per word. s_tdata holds the byte, s_tuser the
// track number, s_tlast marks the final byte of that track's chunk. Bytes of up to
// TRACKS tracks may interleave; each track keeps its own parse context.
// Output stream: one event per word; m_tuser is the event kind, m_tlast marks the
// last event caused by one input byte (a byte causes at most two events).
// Throughput: one byte per cycle while the queue is not full; a byte that causes
// two events fills two output words. The front parser updates the track context
// in the cycle the byte is taken, and a four-entry queue feeds the output stage.
// Each event is written into the queue and then into the output register.
// Stall: when m_tready stays low the queue fills and s_tready falls; nothing is
// dropped. A word on the output holds until taken.
// Reset: all track contexts return to the start of a chunk with time zero, all
// channel programs clear, the queue and the output empty. No pass is needed after
// reset.
module midi_track_event_parser #(
	parameter int TRACKS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [4:0]  s_tuser,   // track_id
	input  logic        s_tlast,   // track_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // event_track, tick_time, channel, note_number,
	                               // note_velocity, instrument, tempo_us
	output logic [2:0]  m_tuser,   // event_kind
	output logic        m_tlast    // last_of_run
);

	logic           full;
	logic           empty;
	logic           push;
	logic           pop;
	mtep_pkg::cmd_t wr_cmd;
	mtep_pkg::cmd_t rd_cmd;

	assign s_tready = !full;

	mtep_front #(.TRACKS(TRACKS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (s_tvalid && s_tready),
		.track_id  (s_tuser),
		.data_byte (s_tdata),
		.track_end (s_tlast),
		.push      (push),
		.cmd       (wr_cmd)
	);

	mtep_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_cmd (rd_cmd)
	);

	mtep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.rd_cmd   (rd_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	typedef struct {
		mtep_pkg::kind_t kind;
		logic [4:0]      trk;
		logic [31:0]     tick;
		logic [3:0]      ch;
		logic [7:0]      note;
		logic [7:0]      vel;
		logic [7:0]      instr;
		logic [23:0]     tempo;
		logic            eor;
	} midi_event_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [4:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	midi_event_t pending_events[$];
	int          fail_count;
	int          bytes_sent;
	int          events_seen;
	bit          quiet;
	bit          busy;
	bit          hold_start;
	bit          hold_done;
	int          hold_off;
	int          rx_idle;

	mtep_pkg::phase_t trk_phase[32];
	logic [1:0]  trk_vcnt[32];
	logic [27:0] trk_vacc[32];
	logic [31:0] trk_time[32];
	logic [7:0]  trk_rstat[32];
	logic [7:0]  trk_cstat[32];
	logic [7:0]  trk_first[32];
	logic [7:0]  trk_mtype[32];
	logic [27:0] trk_skip[32];
	logic [23:0] trk_tempo[32];
	bit          trk_err[32];
	logic [7:0]  chan_prog[16];

	midi_track_event_parser uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_context(int t);
		trk_phase[t] = mtep_pkg::PH_DELTA;
		trk_vcnt[t] = 0;
		trk_vacc[t] = 0;
		trk_time[t] = 0;
		trk_rstat[t] = 0;
		trk_cstat[t] = 0;
		trk_first[t] = 0;
		trk_mtype[t] = 0;
		trk_skip[t] = 0;
		trk_tempo[t] = 0;
		trk_err[t] = 0;
	endfunction

	function automatic bit varlen_done(int t, logic [7:0] b);
		trk_vacc[t] = {trk_vacc[t][20:0], b[6:0]};
		if (b[7] && trk_vcnt[t] < mtep_pkg::VARLEN_LAST) begin
			trk_vcnt[t]++;
			return 0;
		end
		trk_vcnt[t] = 0;
		return 1;
	endfunction

	function automatic midi_event_t make_event(mtep_pkg::kind_t k, int t);
		midi_event_t e;
		e.kind = k;
		e.trk = t[4:0];
		e.tick = trk_time[t];
		e.ch = 0;
		e.note = 0;
		e.vel = 0;
		e.instr = 0;
		e.tempo = 0;
		e.eor = 0;
		return e;
	endfunction

	function automatic void channel_data(int t, logic [7:0] b, ref midi_event_t evs[$]);
		logic [3:0]  hi;
		logic [3:0]  ch;
		midi_event_t e;
		hi = trk_cstat[t][7:4];
		ch = trk_cstat[t][3:0];
		if (trk_phase[t] == mtep_pkg::PH_DATA1) begin
			trk_first[t] = b;
			if (hi == mtep_pkg::HI_PROGRAM) begin
				chan_prog[ch] = b;
				trk_phase[t] = mtep_pkg::PH_DELTA;
			end else if (hi == mtep_pkg::HI_PRESSURE) begin
				trk_phase[t] = mtep_pkg::PH_DELTA;
			end else begin
				trk_phase[t] = mtep_pkg::PH_DATA2;
			end
			return;
		end
		trk_phase[t] = mtep_pkg::PH_DELTA;
		if (hi == mtep_pkg::HI_NOTE_OFF
				|| (hi == mtep_pkg::HI_NOTE_ON && b == 0)) begin
			e = make_event(mtep_pkg::K_OFF, t);
			e.ch = ch;
			e.note = trk_first[t];
			evs.push_back(e);
		end else if (hi == mtep_pkg::HI_NOTE_ON) begin
			e = make_event(mtep_pkg::K_ON, t);
			e.ch = ch;
			e.note = trk_first[t];
			e.vel = b;
			e.instr = chan_prog[ch];
			evs.push_back(e);
		end
	endfunction

	function automatic void parse_byte(int t, logic [7:0] b, ref midi_event_t evs[$]);
		logic [7:0]  ev;
		midi_event_t e;
		case (trk_phase[t])
			mtep_pkg::PH_DELTA: begin
				if (varlen_done(t, b)) begin
					trk_time[t] = trk_time[t] + 32'(trk_vacc[t]);
					trk_vacc[t] = 0;
					trk_phase[t] = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				ev = (b < mtep_pkg::STATUS_BIT) ? trk_rstat[t] : b;
				if (ev < mtep_pkg::STATUS_BIT) begin
					trk_err[t] = 1;
					evs.push_back(make_event(mtep_pkg::K_ERR, t));
				end else if (ev == mtep_pkg::META_STATUS) begin
					trk_phase[t] = mtep_pkg::PH_META_TYPE;
				end else begin
					if (ev < mtep_pkg::SYS_BASE)
						trk_rstat[t] = ev;
					trk_cstat[t] = ev;
					if (ev >= mtep_pkg::SYS_BASE) begin
						trk_vcnt[t] = 0;
						trk_vacc[t] = 0;
						trk_phase[t] = mtep_pkg::PH_SYSEX_LEN;
					end else begin
						trk_phase[t] = mtep_pkg::PH_DATA1;
						if (b < mtep_pkg::STATUS_BIT)
							channel_data(t, b, evs);
					end
				end
			end
			mtep_pkg::PH_DATA1, mtep_pkg::PH_DATA2: channel_data(t, b, evs);
			mtep_pkg::PH_META_TYPE: begin
				trk_mtype[t] = b;
				trk_vcnt[t] = 0;
				trk_vacc[t] = 0;
				trk_phase[t] = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				if (varlen_done(t, b)) begin
					trk_skip[t] = trk_vacc[t];
					trk_vacc[t] = 0;
					if (trk_mtype[t] == mtep_pkg::META_TEMPO) begin
						trk_tempo[t] = 0;
						if (trk_skip[t] == 0) begin
							trk_phase[t] = mtep_pkg::PH_DELTA;
							evs.push_back(make_event(mtep_pkg::K_TEMPO, t));
						end else begin
							trk_phase[t] = mtep_pkg::PH_META_BODY;
						end
					end else begin
						trk_phase[t] = (trk_skip[t] == 0) ? mtep_pkg::PH_DELTA
							: mtep_pkg::PH_SKIP;
					end
				end
			end
			mtep_pkg::PH_META_BODY: begin
				if (trk_vcnt[t] < 3) begin
					trk_tempo[t] = trk_tempo[t] | ({b, 16'h0} >> (8 * trk_vcnt[t]));
					trk_vcnt[t]++;
				end
				trk_skip[t] = trk_skip[t] - 1;
				if (trk_skip[t] == 0) begin
					trk_vcnt[t] = 0;
					trk_phase[t] = mtep_pkg::PH_DELTA;
					e = make_event(mtep_pkg::K_TEMPO, t);
					e.tempo = trk_tempo[t];
					evs.push_back(e);
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				if (varlen_done(t, b)) begin
					trk_skip[t] = trk_vacc[t];
					trk_vacc[t] = 0;
					trk_phase[t] = (trk_skip[t] == 0) ? mtep_pkg::PH_DELTA
						: mtep_pkg::PH_SKIP;
				end
			end
			default: begin
				trk_skip[t] = trk_skip[t] - 1;
				if (trk_skip[t] == 0)
					trk_phase[t] = mtep_pkg::PH_DELTA;
			end
		endcase
	endfunction

	function automatic void predict_events(int t, logic [7:0] b, bit eot);
		midi_event_t evs[$];
		if (!trk_err[t])
			parse_byte(t, b, evs);
		if (eot) begin
			evs.push_back(make_event(mtep_pkg::K_DONE, t));
			clear_context(t);
		end
		if (evs.size() > 0)
			evs[evs.size() - 1].eor = 1;
		foreach (evs[i])
			pending_events.push_back(evs[i]);
	endfunction

	task automatic send_byte(int t, logic [7:0] b, bit eot = 0);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= t[4:0];
		s_tdata <= b;
		s_tlast <= eot;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		predict_events(t, b, eot);
		bytes_sent++;
	endtask

	task automatic send_delta(int t);
		int n;
		n = $urandom_range(1, 4);
		for (int i = 1; i < n; i++)
			send_byte(t, 8'h80 | 8'($urandom_range(0, 127)));
		send_byte(t, 8'($urandom_range(0, 127))
			| (n == 4 && $urandom_range(0, 1) ? 8'h80 : 8'h00));
	endtask

	task automatic send_event(int t);
		int          pick;
		int          len;
		logic [3:0]  hi;
		logic [7:0]  mt;
		pick = $urandom_range(0, 9);
		send_delta(t);
		if (pick < 6) begin
			hi = 4'($urandom_range(8, 14));
			if (trk_rstat[t] >= mtep_pkg::STATUS_BIT && $urandom_range(0, 2) == 0)
				hi = trk_rstat[t][7:4];
			else
				send_byte(t, {hi, 4'($urandom_range(0, 15))});
			len = (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_PRESSURE) ? 1 : 2;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_byte(t, 8'($urandom_range(0, 255)));
				else if (i == 1 && $urandom_range(0, 5) == 0)
					send_byte(t, 8'h00);
				else
					send_byte(t, 8'($urandom_range(0, 127)));
			end
		end else if (pick < 8) begin
			send_byte(t, mtep_pkg::META_STATUS);
			send_byte(t, mtep_pkg::META_TEMPO);
			len = $urandom_range(0, 5);
			send_byte(t, 8'(len));
			repeat (len) send_byte(t, 8'($urandom_range(0, 255)));
		end else if (pick == 8) begin
			send_byte(t, mtep_pkg::META_STATUS);
			mt = 8'($urandom_range(0, 255));
			if (mt == mtep_pkg::META_TEMPO)
				mt = 8'h01;
			send_byte(t, mt);
			len = $urandom_range(0, 3);
			send_byte(t, 8'(len));
			repeat (len) send_byte(t, 8'($urandom_range(0, 255)));
		end else begin
			send_byte(t, $urandom_range(0, 1) ? 8'hf0 : 8'hf7);
			len = $urandom_range(0, 3);
			send_byte(t, 8'(len));
			repeat (len) send_byte(t, 8'($urandom_range(0, 255)));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			rx_idle <= 0;
			hold_off <= 0;
			hold_done <= 0;
		end else if (hold_start && !hold_done) begin
			m_tready <= 0;
			hold_off <= 400;
			hold_done <= 1;
		end else if (hold_off > 0) begin
			m_tready <= 0;
			hold_off <= hold_off - 1;
		end else if (rx_idle > 0) begin
			m_tready <= 0;
			rx_idle <= rx_idle - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			m_tready <= 0;
			rx_idle <= $urandom_range(0, 12);
		end else begin
			m_tready <= 1;
		end
	end

	always @(negedge clk) begin
		midi_event_t e;
		if (arst_n && m_tvalid && m_tready) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				$error("event with nothing expected: kind %0d", m_tuser);
				fail_count++;
			end else begin
				e = pending_events.pop_front();
				if (m_tuser !== e.kind) begin
					$error("event_kind exp %0d got %0d", e.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[4:0] !== e.trk) begin
					$error("event_track exp %0d got %0d", e.trk, m_tdata[4:0]);
					fail_count++;
				end
				if (m_tdata[36:5] !== e.tick) begin
					$error("tick_time exp %0h got %0h", e.tick, m_tdata[36:5]);
					fail_count++;
				end
				if (m_tdata[40:37] !== e.ch) begin
					$error("channel exp %0h got %0h", e.ch, m_tdata[40:37]);
					fail_count++;
				end
				if (m_tdata[48:41] !== e.note) begin
					$error("note_number exp %0h got %0h", e.note, m_tdata[48:41]);
					fail_count++;
				end
				if (m_tdata[56:49] !== e.vel) begin
					$error("note_velocity exp %0h got %0h", e.vel, m_tdata[56:49]);
					fail_count++;
				end
				if (m_tdata[64:57] !== e.instr) begin
					$error("instrument exp %0h got %0h", e.instr, m_tdata[64:57]);
					fail_count++;
				end
				if (m_tdata[88:65] !== e.tempo) begin
					$error("tempo_us exp %0h got %0h", e.tempo, m_tdata[88:65]);
					fail_count++;
				end
				if (m_tlast !== e.eor) begin
					$error("last_of_run exp %0d got %0d", e.eor, m_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		forever begin
			@(posedge clk);
			if (busy && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
				stuck++;
			else
				stuck = 0;
			if (stuck >= 5000) begin
				$display("midi_track_event_parser regression: fail");
				$finish;
			end
		end
	end

	task automatic test_channel_messages();
		send_byte(0, 8'h00);
		send_byte(0, 8'h90);
		send_byte(0, 8'h3c);
		send_byte(0, 8'h7f);
		send_byte(0, 8'h81);
		send_byte(0, 8'h00);
		send_byte(0, 8'h3c);
		send_byte(0, 8'h00);
		send_byte(0, 8'h00);
		send_byte(0, 8'hcf);
		send_byte(0, 8'hff);
		send_byte(0, 8'h00);
		send_byte(0, 8'h9f);
		send_byte(0, 8'hff);
		send_byte(0, 8'h01);
		send_byte(0, 8'h00);
		send_byte(0, 8'h8f);
		send_byte(0, 8'h40);
		send_byte(0, 8'h40);
		send_byte(0, 8'hff);
		send_byte(0, 8'hff);
		send_byte(0, 8'hff);
		send_byte(0, 8'hff);
		send_byte(0, 8'hd3);
		send_byte(0, 8'h11, 1);
	endtask

	task automatic test_meta_and_sysex();
		send_byte(31, 8'h00);
		send_byte(31, mtep_pkg::META_STATUS);
		send_byte(31, mtep_pkg::META_TEMPO);
		send_byte(31, 8'h03);
		send_byte(31, 8'h07);
		send_byte(31, 8'ha1);
		send_byte(31, 8'h20);
		send_byte(31, 8'h05);
		send_byte(31, mtep_pkg::META_STATUS);
		send_byte(31, mtep_pkg::META_TEMPO);
		send_byte(31, 8'h01);
		send_byte(31, 8'hff);
		send_byte(31, 8'h00);
		send_byte(31, mtep_pkg::META_STATUS);
		send_byte(31, mtep_pkg::META_TEMPO);
		send_byte(31, 8'h00);
		send_byte(31, 8'h00);
		send_byte(31, mtep_pkg::META_STATUS);
		send_byte(31, mtep_pkg::META_TEMPO);
		send_byte(31, 8'h05);
		repeat (5) send_byte(31, 8'hab);
		send_byte(31, 8'h00);
		send_byte(31, 8'hf0);
		send_byte(31, 8'h02);
		send_byte(31, 8'hf7);
		send_byte(31, 8'h00, 1);
	endtask

	task automatic test_error_and_end();
		send_byte(1, 8'h00);
		send_byte(1, 8'h10);
		send_byte(1, 8'h00);
		send_byte(1, 8'h90);
		send_byte(1, 8'h00, 1);
		send_byte(2, 8'h00);
		send_byte(2, 8'h92);
		send_byte(2, 8'h30, 1);
		send_byte(2, 8'h00);
		send_byte(2, 8'h30);
		send_byte(2, 8'h05, 1);
	endtask

	task automatic test_backpressure();
		hold_start <= 1;
		repeat (40) send_event(5);
		send_byte(5, 8'h00, 1);
	endtask

	task automatic test_random(int count);
		int t;
		while (bytes_sent < count) begin
			t = $urandom_range(0, 31);
			if ($urandom_range(0, 9) == 0)
				send_byte(t, 8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			else
				send_event(t);
			if ($urandom_range(0, 14) == 0)
				send_byte(t, 8'($urandom_range(0, 255)), 1);
			if (bytes_sent > count - 120)
				quiet = 1;
		end
	endtask

	initial begin
		fail_count = 0;
		bytes_sent = 0;
		events_seen = 0;
		quiet = 0;
		busy = 0;
		hold_start = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		s_tlast = 0;
		arst_n = 0;
		for (int t = 0; t < 32; t++)
			clear_context(t);
		for (int c = 0; c < 16; c++)
			chan_prog[c] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		busy = 1;
		test_channel_messages();
		test_meta_and_sysex();
		test_error_and_end();
		test_backpressure();
		test_random(900);
		s_tvalid <= 0;
		s_tlast <= 0;
		while (pending_events.size() > 0)
			@(posedge clk);
		busy = 0;
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_events.size() == 0)
			$display("midi_track_event_parser regression: pass");
		else
			$display("midi_track_event_parser regression: fail");
		$finish;
	end

endmodule
